/* rtl/core/ifr_pkg.sv */
// Shared constants, types and reply table for the intercom frame responder.
package ifr_pkg;

    localparam int MAX_FRAME_DEF  = 13;
    localparam int TIMER_BITS_DEF = 16;

    localparam logic [7:0] START_BYTE = 8'hFD;

    localparam logic [7:0] TYPE_SHORT  = 8'h11;
    localparam logic [7:0] TYPE_DOOR   = 8'h32;
    localparam logic [7:0] TYPE_INFO   = 8'h61;
    localparam logic [7:0] TYPE_QUERY  = 8'h51;
    localparam logic [7:0] TYPE_STATUS = 8'h73;
    localparam logic [7:0] TYPE_ECHO   = 8'h0B;

    localparam logic [2:0] KIND_SHORT  = 3'd0;
    localparam logic [2:0] KIND_DOOR   = 3'd1;
    localparam logic [2:0] KIND_INFO   = 3'd3;
    localparam logic [2:0] KIND_QUERY  = 3'd4;
    localparam logic [2:0] KIND_STATUS = 3'd5;
    localparam logic [2:0] KIND_ECHO   = 3'd6;

    localparam int IDX_W = 4;

    localparam logic [0:0] OUT_REPLY  = 1'b0;
    localparam logic [0:0] OUT_STATUS = 1'b1;

    localparam logic [0:0] OP_BYTE = 1'b0;
    localparam logic [0:0] OP_TICK = 1'b1;

    typedef struct packed {
        logic       valid;
        logic       status;
        logic       relay_on;
        logic [2:0] kind;
        logic [7:0] h0;
        logic [7:0] h1;
        logic [7:0] h2;
        logic [7:0] echo;
    } t_reply_req;

    typedef struct packed {
        logic       reply;
        logic       door_set;
        logic [7:0] door_value;
        logic [2:0] kind;
        logic [7:0] h0;
        logic [7:0] h1;
        logic [7:0] h2;
        logic [7:0] echo;
    } t_rx_evt;

    function automatic logic [4:0] final_index(input logic [2:0] kind);
        unique case (kind)
            KIND_SHORT:  final_index = 5'd7;
            KIND_DOOR:   final_index = 5'd11;
            KIND_INFO:   final_index = 5'd8;
            KIND_QUERY:  final_index = 5'd13;
            KIND_STATUS: final_index = 5'd7;
            KIND_ECHO:   final_index = 5'd8;
            default:     final_index = 5'd13;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] reply_len(input logic [2:0] kind);
        unique case (kind)
            KIND_INFO:   reply_len = 4'd13;
            KIND_STATUS: reply_len = 4'd10;
            default:     reply_len = 4'd8;
        endcase
    endfunction

    function automatic logic [7:0] reply_byte(input logic [2:0]       kind,
                                              input logic [IDX_W-1:0] idx,
                                              input logic [7:0]       h0,
                                              input logic [7:0]       h1,
                                              input logic [7:0]       h2,
                                              input logic [7:0]       echo);
        logic zero_hdr;
        zero_hdr = (kind == KIND_INFO) || (kind == KIND_QUERY);
        unique case (idx)
            4'd0: reply_byte = START_BYTE;
            4'd1: reply_byte = zero_hdr ? 8'h00 : h0;
            4'd2: reply_byte = zero_hdr ? 8'h00 : h1;
            4'd3: reply_byte = h2;
            4'd4: reply_byte = (kind == KIND_INFO) ? 8'h01 : 8'h51;
            4'd5: begin
                if (kind == KIND_INFO) begin
                    reply_byte = 8'h06;
                end else if (kind == KIND_STATUS) begin
                    reply_byte = 8'h03;
                end else if (kind == KIND_ECHO) begin
                    reply_byte = echo;
                end else begin
                    reply_byte = 8'h01;
                end
            end
            4'd6: reply_byte = (kind == KIND_STATUS) ? 8'h30 : 8'h00;
            4'd7: reply_byte = (kind == KIND_STATUS) ? 8'h10 : 8'h00;
            4'd8: begin
                if (kind == KIND_INFO) begin
                    reply_byte = 8'h20;
                end else if (kind == KIND_STATUS) begin
                    reply_byte = 8'h01;
                end else begin
                    reply_byte = 8'h00;
                end
            end
            4'd9:    reply_byte = (kind == KIND_INFO) ? 8'h90 : 8'h00;
            default: reply_byte = 8'h00;
        endcase
    endfunction

endpackage

/* rtl/core/ifr_frame_rx.sv */
// Frame scanner: start detection, type decode, running sum and header capture.
module ifr_frame_rx #(
    parameter int MAX_FRAME = ifr_pkg::MAX_FRAME_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    output ifr_pkg::t_rx_evt o_evt
);
    import ifr_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic          r_in_frame, n_in_frame;
    logic [CW-1:0] r_count,    n_count;
    logic [2:0]    r_kind,     n_kind;
    logic [7:0]    r_sum,      n_sum;
    logic [7:0]    r_h0,       n_h0;
    logic [7:0]    r_h1,       n_h1;
    logic [7:0]    r_h2,       n_h2;
    logic [7:0]    r_echo,     n_echo;
    logic [CW:0]   nxt;
    logic          drop;
    logic          scan;

    assign nxt = {1'b0, r_count} + {{CW{1'b0}}, 1'b1};

    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_kind     = r_kind;
        n_sum      = r_sum;
        n_h0       = r_h0;
        n_h1       = r_h1;
        n_h2       = r_h2;
        n_echo     = r_echo;
        drop       = 1'b0;
        scan       = 1'b0;
        o_evt      = '0;
        o_evt.kind = r_kind;
        o_evt.h0   = r_h0;
        o_evt.h1   = r_h1;
        o_evt.h2   = r_h2;
        o_evt.echo = r_echo;
        o_evt.door_value = i_byte;
        if (i_valid) begin
            if (!r_in_frame) begin
                scan = 1'b1;
            end else if (nxt > (CW + 1)'(MAX_FRAME)) begin
                drop = 1'b1;
                scan = 1'b1;
            end else begin
                n_count = nxt[CW-1:0];
                n_sum   = r_sum + i_byte;
                if (nxt <= (CW + 1)'(4)) begin
                    if (nxt == (CW + 1)'(2)) begin
                        n_h0 = i_byte;
                    end else if (nxt == (CW + 1)'(3)) begin
                        n_h1 = i_byte;
                    end else begin
                        n_h2 = i_byte;
                    end
                end else if (nxt == (CW + 1)'(5)) begin
                    unique case (i_byte)
                        TYPE_SHORT:  n_kind = KIND_SHORT;
                        TYPE_DOOR:   n_kind = KIND_DOOR;
                        TYPE_INFO:   n_kind = KIND_INFO;
                        TYPE_QUERY:  n_kind = KIND_QUERY;
                        TYPE_STATUS: n_kind = KIND_STATUS;
                        TYPE_ECHO:   n_kind = KIND_ECHO;
                        default:     drop   = 1'b1;
                    endcase
                end else if (5'(nxt) >= final_index(r_kind)) begin
                    o_evt.reply = (i_byte == r_sum);
                    drop        = 1'b1;
                end else begin
                    if (r_kind == KIND_ECHO && nxt == (CW + 1)'(6)) begin
                        n_echo = i_byte;
                    end
                    if (r_kind == KIND_DOOR && nxt == (CW + 1)'(10)) begin
                        o_evt.door_set = 1'b1;
                    end
                end
            end
            if (drop) begin
                n_in_frame = 1'b0;
                n_count    = '0;
                n_kind     = '0;
                n_sum      = '0;
                n_h0       = '0;
                n_h1       = '0;
                n_h2       = '0;
                n_echo     = '0;
            end
            if (scan && i_byte == START_BYTE) begin
                n_in_frame = 1'b1;
                n_count    = CW'(1);
                n_sum      = START_BYTE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_kind     <= '0;
            r_sum      <= '0;
            r_h0       <= '0;
            r_h1       <= '0;
            r_h2       <= '0;
            r_echo     <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_kind     <= n_kind;
            r_sum      <= n_sum;
            r_h0       <= n_h0;
            r_h1       <= n_h1;
            r_h2       <= n_h2;
            r_echo     <= n_echo;
        end
    end

endmodule

/* rtl/core/ifr_reply_gen.sv */
// Result sequencer: walks reply bytes with a running sum and drives the output register.
module ifr_reply_gen (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ifr_pkg::t_reply_req i_req,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_tx_byte,
    output logic               o_relay_on,
    output logic               o_kind,
    output logic               o_last
);
    import ifr_pkg::*;

    logic             r_busy;
    logic             r_status;
    logic             r_relay_on;
    logic [2:0]       r_kind;
    logic [7:0]       r_h0, r_h1, r_h2, r_echo;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_len;
    logic [7:0]       r_sum;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_relay;
    logic             r_out_kind;
    logic             r_out_last;
    logic             out_load;
    logic             cur_last;
    logic             emit;
    logic [7:0]       cur_byte;
    logic [7:0]       tbl_byte;

    assign out_load = !r_out_valid || i_ready;
    assign cur_last = r_status || (r_idx == r_len - IDX_W'(1));
    assign emit     = r_busy && out_load;
    assign o_free   = !r_busy || (emit && cur_last);
    assign tbl_byte = reply_byte(r_kind, r_idx, r_h0, r_h1, r_h2, r_echo);
    assign cur_byte = r_status ? 8'h00 : (cur_last ? r_sum : tbl_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.valid && o_free) begin
                r_busy <= 1'b1;
            end else if (emit && cur_last) begin
                r_busy <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && o_free) begin
            r_status   <= i_req.status;
            r_relay_on <= i_req.relay_on;
            r_kind     <= i_req.kind;
            r_h0       <= i_req.h0;
            r_h1       <= i_req.h1;
            r_h2       <= i_req.h2;
            r_echo     <= i_req.echo;
            r_idx      <= '0;
            r_len      <= reply_len(i_req.kind);
            r_sum      <= '0;
        end else if (emit) begin
            r_idx <= r_idx + IDX_W'(1);
            r_sum <= r_sum + tbl_byte;
        end
        if (emit) begin
            r_out_byte  <= cur_byte;
            r_out_relay <= r_status && r_relay_on;
            r_out_kind  <= r_status ? OUT_STATUS : OUT_REPLY;
            r_out_last  <= cur_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_tx_byte  = r_out_byte;
    assign o_relay_on = r_out_relay;
    assign o_kind     = r_out_kind;
    assign o_last     = r_out_last;

endmodule

/* rtl/core/intercom_frame_responder.sv */
// Top level of the intercom frame responder: input register, tick logic and result path.
//
// One item enters per cycle while the reply sequencer is free. Received bytes and ticks
// pass an input register and are handled from it once the reply sequencer is free; a tick
// yields one status transaction and a byte that closes a valid frame yields a reply of
// 8, 10 or 13 transactions. The reply sequencer emits one transaction per cycle into the
// output register while the output side is ready, so a reply holds off the following
// item until its last transaction is emitted. Output back-pressure stalls the sequencer
// and, through it, the input. The debounce register may be written at any time the block
// is idle.
module intercom_frame_responder #(
    parameter int MAX_FRAME  = ifr_pkg::MAX_FRAME_DEF,
    parameter int TIMER_BITS = ifr_pkg::TIMER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], button_level[8], zero fill
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // tx_byte[7:0], relay_on[8], zero fill
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast,   // last
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    import ifr_pkg::*;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
    localparam logic [15:0]           DEB_MAX   = '1;

    logic                  r_in_valid;
    logic                  r_in_op;
    logic [7:0]            r_in_byte;
    logic                  r_in_lvl;
    logic [15:0]           r_deb_ticks;
    logic [7:0]            r_door_hold,  n_door_hold;
    logic [TIMER_BITS-1:0] r_relay,      n_relay;
    logic                  r_stable,     n_stable;
    logic                  r_cand,       n_cand;
    logic [15:0]           r_deb,        n_deb;
    logic                  gen_free;
    logic                  consume;
    logic                  tick;
    logic                  relay_on;
    logic [15:0]           deb_inc;
    logic [TIMER_BITS-1:0] relay_base;
    t_rx_evt               rx_evt;
    t_reply_req            req;
    logic [7:0]            tx_byte;
    logic                  tx_relay;

    assign consume       = r_in_valid && gen_free;
    assign s_axis_tready = !r_in_valid || consume;
    assign tick          = consume && (r_in_op == OP_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= s_axis_tuser;
            r_in_byte <= s_axis_tdata[7:0];
            r_in_lvl  <= s_axis_tdata[8];
        end
    end

    ifr_frame_rx #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame_rx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (consume && (r_in_op == OP_BYTE)),
        .i_byte  (r_in_byte),
        .o_evt   (rx_evt)
    );

    assign deb_inc = (r_deb == DEB_MAX) ? r_deb : r_deb + 16'd1;

    always_comb begin
        n_door_hold = r_door_hold;
        n_relay     = r_relay;
        n_stable    = r_stable;
        n_cand      = r_cand;
        n_deb       = r_deb;
        relay_base  = r_relay;
        relay_on    = 1'b0;
        if (tick) begin
            n_deb = deb_inc;
            if (r_in_lvl != r_stable && deb_inc > r_deb_ticks) begin
                if (r_cand != r_in_lvl) begin
                    n_cand = r_in_lvl;
                    n_deb  = '0;
                end else begin
                    n_stable   = r_in_lvl;
                    relay_base = '0;
                end
            end
            relay_on = relay_base < {{(TIMER_BITS - 8){1'b0}}, r_door_hold};
            n_relay  = (relay_base == TIMER_MAX) ? relay_base
                                                 : relay_base + TIMER_BITS'(1);
        end else if (rx_evt.door_set) begin
            n_door_hold = rx_evt.door_value;
            n_relay     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_ticks <= 16'd50;
            r_door_hold <= '0;
            r_relay     <= '0;
            r_stable    <= 1'b0;
            r_cand      <= 1'b0;
            r_deb       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_deb_ticks <= i_cfg_wdata;
            end
            r_door_hold <= n_door_hold;
            r_relay     <= n_relay;
            r_stable    <= n_stable;
            r_cand      <= n_cand;
            r_deb       <= n_deb;
        end
    end

    always_comb begin
        req          = '0;
        req.valid    = tick || rx_evt.reply;
        req.status   = tick;
        req.relay_on = relay_on;
        req.kind     = rx_evt.kind;
        req.h0       = rx_evt.h0;
        req.h1       = rx_evt.h1;
        req.h2       = rx_evt.h2;
        req.echo     = rx_evt.echo;
    end

    ifr_reply_gen u_reply_gen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_free     (gen_free),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_tx_byte  (tx_byte),
        .o_relay_on (tx_relay),
        .o_kind     (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, tx_relay, tx_byte};

endmodule

/* bench/intercom_frame_responder_tb.sv */
// Stream testbench for intercom_frame_responder: self-predicting, randomized flow control.
`timescale 1ns / 1ps

module intercom_frame_responder_tb;
    import ifr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS = 22;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       level;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx;
        logic       last;
        logic       relay_on;
    } t_tx_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'd0;
    logic        s_axis_tuser = OP_BYTE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = 16'd0;

    t_in_item rx_pending[$];
    t_tx_item expected_tx[$];

    // predicted block state
    bit          frm_open;
    int unsigned frm_count;
    logic [2:0]  frm_kind;
    logic [7:0]  frm_sum;
    logic [7:0]  frm_hdr [3];
    logic [7:0]  frm_echo;
    logic [7:0]  hold_ticks;
    logic [15:0] relay_age;
    logic        btn_stable;
    logic        btn_candidate;
    logic [15:0] btn_age;
    logic [15:0] debounce_limit;

    int          fail_count;
    int          reply_count;
    int          status_count;
    int          bytes_in;
    int          ticks_in;
    int          checked_count;
    int unsigned cycle_count;
    int          phase_items;

    bit          in_fire;
    int          burst_left;
    int          gap_left;
    bit          sender_steady;
    bit          receiver_steady;
    logic [31:0] ready_pat;
    int          pat_left;

    intercom_frame_responder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic clear_frame();
        frm_open = 1'b0;
        frm_count = 0;
        frm_kind = KIND_SHORT;
        frm_sum = 8'd0;
        frm_hdr[0] = 8'd0;
        frm_hdr[1] = 8'd0;
        frm_hdr[2] = 8'd0;
        frm_echo = 8'd0;
    endtask

    task automatic advance_responder(input t_in_item it);
        int unsigned n;
        int unsigned close_at;
        logic [7:0]  r [13];
        int          len;
        logic [7:0]  s;
        t_tx_item    o;
        if (it.op == OP_TICK) begin
            ticks_in++;
            if (btn_age != 16'hFFFF) btn_age++;
            if (it.level != btn_stable && btn_age > debounce_limit) begin
                if (btn_candidate != it.level) begin
                    btn_candidate = it.level;
                    btn_age = 16'd0;
                end else begin
                    btn_stable = it.level;
                    relay_age = 16'd0;
                end
            end
            o.kind = OUT_STATUS;
            o.tx = 8'd0;
            o.last = 1'b1;
            o.relay_on = (relay_age < {8'd0, hold_ticks});
            if (relay_age != 16'hFFFF) relay_age++;
            expected_tx.push_back(o);
            return;
        end
        bytes_in++;
        if (frm_open) begin
            n = frm_count + 1;
            if (n > MAX_FRAME_DEF) begin
                clear_frame();
            end else begin
                frm_count = n;
                if (n <= 4) begin
                    frm_hdr[n - 2] = it.data;
                end else if (n == 5) begin
                    case (it.data)
                        TYPE_SHORT:  frm_kind = KIND_SHORT;
                        TYPE_DOOR:   frm_kind = KIND_DOOR;
                        TYPE_INFO:   frm_kind = KIND_INFO;
                        TYPE_QUERY:  frm_kind = KIND_QUERY;
                        TYPE_STATUS: frm_kind = KIND_STATUS;
                        TYPE_ECHO:   frm_kind = KIND_ECHO;
                        default: begin
                            clear_frame();
                            return;
                        end
                    endcase
                end else begin
                    case (frm_kind)
                        KIND_SHORT:  close_at = 7;
                        KIND_DOOR:   close_at = 11;
                        KIND_INFO:   close_at = 8;
                        KIND_QUERY:  close_at = 13;
                        KIND_STATUS: close_at = 7;
                        KIND_ECHO:   close_at = 8;
                        default:     close_at = 13;
                    endcase
                    if (n >= close_at) begin
                        if (it.data == frm_sum) begin
                            for (int i = 0; i < 13; i++) r[i] = 8'd0;
                            r[0] = START_BYTE;
                            r[1] = frm_hdr[0];
                            r[2] = frm_hdr[1];
                            r[3] = frm_hdr[2];
                            r[4] = 8'h51;
                            r[5] = 8'h01;
                            len = 8;
                            case (frm_kind)
                                KIND_INFO: begin
                                    r[1] = 8'd0;
                                    r[2] = 8'd0;
                                    r[4] = 8'h01;
                                    r[5] = 8'h06;
                                    r[8] = 8'h20;
                                    r[9] = 8'h90;
                                    len = 13;
                                end
                                KIND_QUERY: begin
                                    r[1] = 8'd0;
                                    r[2] = 8'd0;
                                end
                                KIND_STATUS: begin
                                    r[5] = 8'h03;
                                    r[6] = 8'h30;
                                    r[7] = 8'h10;
                                    r[8] = 8'h01;
                                    len = 10;
                                end
                                KIND_ECHO: r[5] = frm_echo;
                                default: ;
                            endcase
                            s = 8'd0;
                            for (int i = 0; i < len - 1; i++) s = s + r[i];
                            r[len - 1] = s;
                            for (int i = 0; i < len; i++) begin
                                o.kind = OUT_REPLY;
                                o.tx = r[i];
                                o.last = (i == len - 1);
                                o.relay_on = 1'b0;
                                expected_tx.push_back(o);
                            end
                            reply_count++;
                        end
                        clear_frame();
                        return;
                    end
                    if (frm_kind == KIND_ECHO && n == 6) frm_echo = it.data;
                    if (frm_kind == KIND_DOOR && n == 10) begin
                        hold_ticks = it.data;
                        relay_age = 16'd0;
                    end
                end
                frm_sum = frm_sum + it.data;
                return;
            end
        end
        if (it.data == START_BYTE) begin
            frm_open = 1'b1;
            frm_count = 1;
            frm_sum = START_BYTE;
        end
    endtask

    task automatic queue_byte(input logic [7:0] b);
        t_in_item it;
        it.op = OP_BYTE;
        it.data = b;
        it.level = 1'($urandom_range(0, 1));
        rx_pending.push_back(it);
        phase_items++;
    endtask

    task automatic queue_tick(input logic lvl);
        t_in_item it;
        it.op = OP_TICK;
        it.data = 8'($urandom);
        it.level = lvl;
        rx_pending.push_back(it);
        phase_items++;
    endtask

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 5))
            0:       return TYPE_SHORT;
            1:       return TYPE_DOOR;
            2:       return TYPE_INFO;
            3:       return TYPE_QUERY;
            4:       return TYPE_STATUS;
            default: return TYPE_ECHO;
        endcase
    endfunction

    // fill < 0 gives random body bytes; an unknown type stops after the type byte
    task automatic queue_frame(input logic [7:0] ftype, input bit good_sum, input int fill);
        logic [7:0] b [13];
        int         len;
        logic [7:0] s;
        case (ftype)
            TYPE_SHORT:  len = 7;
            TYPE_DOOR:   len = 11;
            TYPE_INFO:   len = 8;
            TYPE_QUERY:  len = 13;
            TYPE_STATUS: len = 7;
            TYPE_ECHO:   len = 8;
            default:     len = 5;
        endcase
        b[0] = START_BYTE;
        for (int i = 1; i < 13; i++) b[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
        b[4] = ftype;
        if (ftype == TYPE_DOOR && fill < 0 && $urandom_range(0, 1) == 1)
            b[9] = 8'($urandom_range(0, 8));
        if (len > 5) begin
            s = 8'd0;
            for (int i = 0; i < len - 1; i++) s = s + b[i];
            b[len - 1] = good_sum ? s : s + 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < len; i++) queue_byte(b[i]);
    endtask

    task automatic write_debounce(input logic [15:0] value);
        while (rx_pending.size() != 0 || expected_tx.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        debounce_limit = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_random_phase();
        int         pick;
        logic [7:0] t;
        logic       lvl;
        lvl = btn_stable;
        phase_items = 0;
        while (phase_items < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 4) begin
                queue_frame(pick_type(), 1'b1, -1);
            end else if (pick == 5) begin
                queue_frame(pick_type(), 1'b0, -1);
            end else if (pick == 6) begin
                do t = 8'($urandom);
                while (t == TYPE_SHORT || t == TYPE_DOOR || t == TYPE_INFO ||
                       t == TYPE_QUERY || t == TYPE_STATUS || t == TYPE_ECHO);
                queue_frame(t, 1'b1, -1);
            end else if (pick == 7) begin
                t = 8'($urandom);
                // a rare stray start byte misaligns the next frame
                if (t == START_BYTE && $urandom_range(0, 3) != 0) t = 8'h00;
                queue_byte(t);
                if (t != START_BYTE) phase_items--;
            end else begin
                if ($urandom_range(0, 1) == 1) lvl = ~lvl;
                repeat ($urandom_range(1, 8)) queue_tick(lvl);
            end
        end
    endtask

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles at %0t", cycle_count, $time);
            $display("intercom_frame_responder verification failed");
            $finish;
        end
    end

    // input acceptance and prediction
    always @(posedge i_clk) begin
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire) advance_responder(rx_pending.pop_front());
    end

    // sender: bursts with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (rx_pending.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= rx_pending[0].op;
                s_axis_tdata <= {7'd0, rx_pending[0].level, rx_pending[0].data};
                if (burst_left == 0) burst_left = $urandom_range(1, 12);
                burst_left--;
                if (burst_left == 0 && !sender_steady) gap_left = $urandom_range(1, 6);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall pattern, reloaded after each full rotation
    always @(negedge i_clk) begin
        if (pat_left == 0) begin
            ready_pat = $urandom | 32'h1;
            pat_left = 32;
        end
        m_axis_tready <= receiver_steady || ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[31:1]};
        pat_left--;
    end

    // result checking
    always @(posedge i_clk) begin
        t_tx_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_tx.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected transaction kind=%0d tx=%02h last=%0d relay=%0d",
                         $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast,
                         m_axis_tdata[8]);
            end else begin
                want = expected_tx.pop_front();
                checked_count++;
                if (want.kind == OUT_STATUS) status_count++;
                if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.tx ||
                    m_axis_tlast !== want.last || m_axis_tdata[8] !== want.relay_on) begin
                    fail_count++;
                    $display("%0t: mismatch expected kind=%0d tx=%02h last=%0d relay=%0d",
                             $time, want.kind, want.tx, want.last, want.relay_on);
                    $display("%0t:          actual kind=%0d tx=%02h last=%0d relay=%0d",
                             $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast,
                             m_axis_tdata[8]);
                end
            end
        end
    end

    initial begin
        clear_frame();
        hold_ticks = 8'd0;
        relay_age = 16'd0;
        btn_stable = 1'b0;
        btn_candidate = 1'b0;
        btn_age = 16'd0;
        debounce_limit = 16'd50;
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_debounce(16'd0);
        queue_byte(8'hFF);
        queue_frame(TYPE_DOOR, 1'b1, 8'hFD);
        queue_tick(1'b1);
        queue_tick(1'b1);
        queue_frame(8'h77, 1'b1, 8'h00);
        queue_frame(TYPE_ECHO, 1'b1, 8'hFF);
        queue_random_phase();

        write_debounce(16'd1);
        queue_random_phase();

        write_debounce(16'hFFFF);
        sender_steady = 1'b1;
        receiver_steady = 1'b1;
        queue_random_phase();

        write_debounce(16'($urandom_range(2, 6)));
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
        queue_random_phase();

        write_debounce(16'd4);
        receiver_steady = 1'b1;
        queue_random_phase();

        while (rx_pending.size() != 0 || expected_tx.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d byte and %0d tick items over five debounce settings",
                 bytes_in, ticks_in);
        $display("checked %0d transactions: %0d replies, %0d status reports",
                 checked_count, reply_count, status_count);
        if (fail_count == 0) begin
            $display("intercom_frame_responder verification clean");
        end else begin
            $display("intercom_frame_responder verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ifr_pkg.sv
rtl/core/ifr_frame_rx.sv
rtl/core/ifr_reply_gen.sv
rtl/core/intercom_frame_responder.sv
bench/intercom_frame_responder_tb.sv
